>>> hdl/wsfd_pkg.sv
// shared types and constants of the websocket frame deframer
package wsfd_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 7;
	localparam int unsigned OPCODE_W = 4;
	localparam int unsigned ERR_W    = 3;
	localparam int unsigned KEY_W    = 32;

	localparam logic [LEN_W-1:0]    LEN_LIMIT         = 7'd125;
	localparam logic [LEN_W-1:0]    MAX_PAYLOAD_RESET = 7'd125;
	localparam logic [OPCODE_W-1:0] OP_DATA_MAX       = 4'h7;
	localparam logic [OPCODE_W-1:0] OP_CONTINUATION   = 4'h0;

	// one-hot parser phases
	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_LEN  = 5'b00010,
		PH_KEY  = 5'b00100,
		PH_DATA = 5'b01000,
		PH_SKIP = 5'b10000
	} phase_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE         = 3'd0,
		ERR_RESERVED     = 3'd1,
		ERR_CONTINUATION = 3'd2,
		ERR_CONTROL_LEN  = 3'd3,
		ERR_LENGTH       = 3'd4
	} err_code_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              frame_first;
	} in_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   payload_byte;
		logic                payload_valid;
		logic                payload_last;
		logic [OPCODE_W-1:0] frame_opcode;
		logic [ERR_W-1:0]    error_code;
	} result_t;

endpackage

>>> hdl/wsfd_in_stage.sv
// input register stage of the deframer
module wsfd_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  wsfd_pkg::in_word_t in_word,
	input  logic              take,
	output logic              valid_s1,
	output wsfd_pkg::in_word_t word_s1
);
	import wsfd_pkg::*;

	logic     valid_q;
	in_word_t word_q;

	assign in_ready = !valid_q || take;
	assign valid_s1 = valid_q;
	assign word_s1  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_q <= in_word;
		end
	end

endmodule

>>> hdl/wsfd_parser.sv
// header decode, key capture and unmasking, one byte per step
module wsfd_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  wsfd_pkg::in_word_t              word,
	input  logic                            cfg_we,
	input  logic [wsfd_pkg::LEN_W-1:0]      cfg_wdata,
	output logic                            has_res,
	output wsfd_pkg::result_t               res
);
	import wsfd_pkg::*;

	phase_t              phase_q,  phase_d;
	logic [OPCODE_W-1:0] opcode_q, opcode_d;
	logic                mask_q,   mask_d;
	logic [KEY_W-1:0]    key_q,    key_d;
	logic [1:0]          kbs_q,    kbs_d;
	logic [LEN_W-1:0]    rem_q,    rem_d;
	logic [1:0]          idx_q,    idx_d;
	logic [LEN_W-1:0]    max_len_q;

	logic [BYTE_W-1:0] b;
	logic [LEN_W-1:0]  len;
	logic              too_long;
	logic              over_max;
	logic              is_ctrl;
	logic [BYTE_W-1:0] key_byte;

	assign b        = word.data_byte;
	assign len      = b[LEN_W-1:0];
	assign is_ctrl  = opcode_q > OP_DATA_MAX;
	assign too_long = len > LEN_LIMIT;
	assign over_max = !is_ctrl && (len > max_len_q);
	assign key_byte = mask_q ? key_q[{idx_q, 3'b000} +: BYTE_W] : '0;

	always_comb begin
		phase_d  = phase_q;
		opcode_d = opcode_q;
		mask_d   = mask_q;
		key_d    = key_q;
		kbs_d    = kbs_q;
		rem_d    = rem_q;
		idx_d    = idx_q;
		has_res  = 1'b0;
		res      = '0;
		res.frame_opcode = opcode_q;

		if (word.frame_first) begin
			opcode_d = b[OPCODE_W-1:0];
			mask_d   = 1'b0;
			key_d    = '0;
			kbs_d    = '0;
			rem_d    = '0;
			idx_d    = '0;
			res.frame_opcode = b[OPCODE_W-1:0];
			if (b[6:4] != 3'b000) begin
				phase_d          = PH_SKIP;
				has_res          = 1'b1;
				res.payload_last = 1'b1;
				res.error_code   = ERR_RESERVED;
			end else if (!b[7] && (b[OPCODE_W-1:0] == OP_CONTINUATION)) begin
				phase_d          = PH_SKIP;
				has_res          = 1'b1;
				res.payload_last = 1'b1;
				res.error_code   = ERR_CONTINUATION;
			end else begin
				phase_d = PH_LEN;
			end
		end else begin
			case (phase_q)
				PH_LEN: begin
					mask_d = b[7];
					if (is_ctrl && too_long) begin
						phase_d          = PH_SKIP;
						has_res          = 1'b1;
						res.payload_last = 1'b1;
						res.error_code   = ERR_CONTROL_LEN;
					end else if (too_long || over_max) begin
						phase_d          = PH_SKIP;
						has_res          = 1'b1;
						res.payload_last = 1'b1;
						res.error_code   = ERR_LENGTH;
					end else begin
						rem_d = len;
						idx_d = '0;
						if (b[7]) begin
							kbs_d   = '0;
							phase_d = PH_KEY;
						end else if (len == '0) begin
							// empty frame closes at once
							phase_d          = PH_IDLE;
							has_res          = 1'b1;
							res.payload_last = 1'b1;
						end else begin
							phase_d = PH_DATA;
						end
					end
				end
				PH_KEY: begin
					key_d[{kbs_q, 3'b000} +: BYTE_W] = b;
					if (kbs_q == 2'd3) begin
						kbs_d = '0;
						if (rem_q == '0) begin
							phase_d          = PH_IDLE;
							has_res          = 1'b1;
							res.payload_last = 1'b1;
						end else begin
							phase_d = PH_DATA;
						end
					end else begin
						kbs_d = kbs_q + 2'd1;
					end
				end
				PH_DATA: begin
					idx_d             = idx_q + 2'd1;
					rem_d             = rem_q - 7'd1;
					has_res           = 1'b1;
					res.payload_byte  = b ^ key_byte;
					res.payload_valid = 1'b1;
					res.payload_last  = (rem_q == 7'd1);
					if (rem_q == 7'd1) begin
						phase_d = PH_IDLE;
					end
				end
				default: begin
					// idle or discarding: stray bytes dropped
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			opcode_q <= '0;
			mask_q   <= 1'b0;
			key_q    <= '0;
			kbs_q    <= '0;
			rem_q    <= '0;
			idx_q    <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			mask_q   <= mask_d;
			key_q    <= key_d;
			kbs_q    <= kbs_d;
			rem_q    <= rem_d;
			idx_q    <= idx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_PAYLOAD_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

endmodule

>>> hdl/wsfd_out_stage.sv
// result register toward the output stream
module wsfd_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  wsfd_pkg::result_t res,
	output logic              free,
	input  logic              out_ready,
	output logic              out_valid,
	output wsfd_pkg::result_t out_res
);
	import wsfd_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

>>> hdl/websocket_frame_deframer_unit.sv
// top level of the websocket frame deframer
// Deframes a received websocket byte stream (base framing, 7-bit lengths only).
// One byte enters per word on the slave stream, tuser high on the first byte
// of each frame. The block decodes the two-byte header, collects the four-byte
// masking key when the mask bit is set and then sends each payload byte
// unmasked, tlast on the final one. A header error (reserved bits set, fin clear
// on a continuation, any payload over 125, or a data payload over max_payload_len)
// gives one error word with tlast and the rest of the frame is dropped; an empty
// frame gives one empty word with tlast. Header and key bytes give no output.
// Rate: one byte per cycle sustained while m_axis_tready stays high. Each byte
// is held in the input register and then decoded into the result register,
// which offers its result on the output stream; the parser state update is
// the only loop.
// cfg_wdata is taken whenever cfg_we is high and must only change while the
// block is idle.
module websocket_frame_deframer_unit (
	input  logic       clk,
	input  logic       arst_n,
	// configuration: max_payload_len
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	// received bytes
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tuser,   // [0] frame_first
	// results
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
	output logic [7:0] m_axis_tuser,   // [0] payload_valid, [4:1] frame_opcode, [7:5] error_code
	output logic       m_axis_tlast    // payload_last
);
	import wsfd_pkg::*;

	in_word_t in_word;
	in_word_t word_s1;
	logic     valid_s1;
	logic     out_free;
	logic     take;
	logic     has_res;
	result_t  res;
	result_t  out_res;

	assign in_word.data_byte   = s_axis_tdata;
	assign in_word.frame_first = s_axis_tuser;

	// a byte leaves the input register once the result register can take its result
	assign take = valid_s1 && out_free;

	wsfd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_word  (in_word),
		.take     (take),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	wsfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (take),
		.word      (word_s1),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.has_res   (has_res),
		.res       (res)
	);

	wsfd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && has_res),
		.res       (res),
		.free      (out_free),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_res   (out_res)
	);

	// pack the result word
	assign m_axis_tdata      = out_res.payload_byte;
	assign m_axis_tuser[0]   = out_res.payload_valid;
	assign m_axis_tuser[4:1] = out_res.frame_opcode;
	assign m_axis_tuser[7:5] = out_res.error_code;
	assign m_axis_tlast      = out_res.payload_last;

endmodule

>>> hdl/wsfd_checker.sv
// port-level assertions for the deframer, bound to the top level
module wsfd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic [6:0] cfg_wdata,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic       s_axis_tuser,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [7:0] m_axis_tuser,
	input logic       m_axis_tlast
);
	import wsfd_pkg::*;

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result word changed");

	// a word without payload is always the end of a frame and carries zero data
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 8'd0))
		else $error("non-payload word without tlast or with data");

	// error words never carry payload
	a_err_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[7:5] != ERR_NONE) |-> !m_axis_tuser[0])
		else $error("error word flagged as payload");

	// only defined error codes appear
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[7:5] == ERR_NONE) || (m_axis_tuser[7:5] == ERR_RESERVED)
			|| (m_axis_tuser[7:5] == ERR_CONTINUATION)
			|| (m_axis_tuser[7:5] == ERR_CONTROL_LEN) || (m_axis_tuser[7:5] == ERR_LENGTH))
		else $error("undefined error code");

endmodule

bind websocket_frame_deframer_unit wsfd_checker u_wsfd_checker (.*);
